// ----- hw/rtl/outer_product_mac_4x4_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the outer-product tile accumulator.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OUTER_PRODUCT_MAC_4X4_ASSERT_SVH
`define OUTER_PRODUCT_MAC_4X4_ASSERT_SVH

// Same-cycle implication.
`define OPMAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OPMAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/opmac_pkg.sv -----
// ----------------------------------------------------------------------------
// opmac_pkg
// Shared defaults and the control word that travels along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package opmac_pkg;

  localparam int TILE_DEF       = 4;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 48;

  // Control that rides with each step from one cell to the next.
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/outer_product_mac_4x4.sv -----
// ----------------------------------------------------------------------------
// outer_product_mac_4x4
// 4x4 outer-product multiply-accumulate tile, built as a chain of row cells.
// ----------------------------------------------------------------------------
// Usage. Each input beat on the s_axis channel carries one step of the inner
// dimension: TILE A values (one per tile row) and TILE B values (one per tile
// column). s_axis_tlast marks the final step of a tile. Every step is added as
// an outer product into TILE*TILE saturating accumulators. After the final
// step the tile leaves on m_axis as TILE beats, row 0 first, with the row
// number in m_axis_tuser and m_axis_tlast on the last row; the accumulators
// are then zero for the next tile.
// Throughput is one step per cycle while no cell is held. The steps travel
// down a chain of row cells, one cell per cycle when not held. Each cell
// registers its products as the step enters it and folds them into its
// accumulators as the step moves on to the next cell, so the rows of a tile
// reach their output slots in row order after the last step is taken.
// Each row has one output slot. When the receiver stalls, a cell whose slot is
// still full holds the final step of the next tile, together with every cell
// ahead of it and the input; cells further down keep running.
// Reset clears the accumulators, the output slots and the row pointer, and the
// input is not ready while reset is high.
// ----------------------------------------------------------------------------
`default_nettype none

module outer_product_mac_4x4 #(
  parameter int TILE       = opmac_pkg::TILE_DEF,
  parameter int DATA_WIDTH = opmac_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = opmac_pkg::ACC_WIDTH_DEF,
  localparam int ITW = ((2 * TILE * DATA_WIDTH + 7) / 8) * 8,
  localparam int OTW = ((TILE * ACC_WIDTH + 7) / 8) * 8,
  localparam int RIW = (TILE > 1) ? $clog2(TILE) : 1
) (
  input  logic           clk,
  input  logic           rst,
  // a_row0..a_row(TILE-1), then b_col0..b_col(TILE-1), DATA_WIDTH bits each.
  input  logic [ITW-1:0] s_axis_tdata,
  input  logic           s_axis_tlast,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // sum_col0..sum_col(TILE-1), ACC_WIDTH bits each.
  output logic [OTW-1:0] m_axis_tdata,
  // row_index.
  output logic [RIW-1:0] m_axis_tuser,
  output logic           m_axis_tlast,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready
);

  // Links between cells: entry 0 is the input beat, entry r+1 leaves cell r.
  opmac_pkg::ctl_t                  lnk_ctl [TILE+1];
  logic [TILE-1:0][DATA_WIDTH-1:0]  lnk_a   [TILE+1];
  logic [TILE-1:0][DATA_WIDTH-1:0]  lnk_b   [TILE+1];
  opmac_pkg::ctl_t                  cell_ctl [TILE];

  logic [TILE-1:0]                  fin;
  logic [TILE-1:0][ACC_WIDTH-1:0]   fin_sums [TILE];
  logic [TILE-1:0]                  blocked;
  logic [TILE-1:0]                  stall;
  logic [TILE-1:0]                  drain_row;
  logic                             drain;

  // Output slots, one per tile row, read in row order.
  logic [TILE-1:0][ACC_WIDTH-1:0]   done_sums [TILE];
  logic [TILE-1:0]                  done_full;
  logic [RIW-1:0]                   rd_ptr;

  always_comb begin
    for (int r = 0; r < TILE; r++) begin
      lnk_a[0][r] = s_axis_tdata[r*DATA_WIDTH +: DATA_WIDTH];
      lnk_b[0][r] = s_axis_tdata[(TILE+r)*DATA_WIDTH +: DATA_WIDTH];
    end
  end
  assign lnk_ctl[0] = '{valid: s_axis_tvalid && s_axis_tready, last: s_axis_tlast};

  for (genvar r = 0; r < TILE; r++) begin : g_cell
    opmac_cell #(
      .TILE       (TILE),
      .DATA_WIDTH (DATA_WIDTH),
      .ACC_WIDTH  (ACC_WIDTH),
      .ROW        (r)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .stall    (stall[r]),
      .in_ctl   (lnk_ctl[r]),
      .in_a     (lnk_a[r]),
      .in_b     (lnk_b[r]),
      .out_ctl  (cell_ctl[r]),
      .out_a    (lnk_a[r+1]),
      .out_b    (lnk_b[r+1]),
      .fin      (fin[r]),
      .fin_sums (fin_sums[r])
    );

    // A held cell passes a bubble down so its step is handed on only once.
    assign lnk_ctl[r+1] = '{valid: cell_ctl[r].valid && !stall[r], last: cell_ctl[r].last};

    // A finishing row waits while its slot still holds the previous tile's row.
    assign blocked[r]   = fin[r] && done_full[r] && !drain_row[r];
    assign drain_row[r] = drain && (rd_ptr == RIW'(r));
  end

  // A held cell also holds everything upstream of it.
  always_comb begin
    stall[TILE-1] = blocked[TILE-1];
    for (int r = TILE - 2; r >= 0; r--) begin
      stall[r] = blocked[r] || stall[r+1];
    end
  end

  assign s_axis_tready = !stall[0] && !rst;

  assign m_axis_tvalid = done_full[rd_ptr];
  assign m_axis_tdata  = OTW'(done_sums[rd_ptr]);
  assign m_axis_tuser  = rd_ptr;
  assign m_axis_tlast  = (rd_ptr == RIW'(TILE - 1));
  assign drain         = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_full <= '0;
      rd_ptr    <= '0;
    end else begin
      for (int r = 0; r < TILE; r++) begin
        if (fin[r] && !stall[r]) begin
          done_full[r] <= 1'b1;
        end else if (drain_row[r]) begin
          done_full[r] <= 1'b0;
        end
      end
      if (drain) begin
        rd_ptr <= m_axis_tlast ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < TILE; r++) begin
      if (fin[r] && !stall[r]) begin
        done_sums[r] <= fin_sums[r];
      end
    end
  end

  `include "outer_product_mac_4x4_assert.svh"

  `OPMAC_ASSERT_NOW(a_ready_when_slots_empty, done_full == '0, s_axis_tready,
                    "input held although every output slot is empty")
  `OPMAC_ASSERT_NEXT(a_ptr_wraps_after_tile, drain && m_axis_tlast, rd_ptr == '0,
                     "row pointer did not return to row 0 after the last row")

endmodule

`default_nettype wire

// ----- hw/rtl/opmac_cell.sv -----
// ----------------------------------------------------------------------------
// opmac_cell
// One tile row: registered products, saturating accumulators, forward of the step.
// ----------------------------------------------------------------------------
`default_nettype none

module opmac_cell #(
  parameter int TILE       = opmac_pkg::TILE_DEF,
  parameter int DATA_WIDTH = opmac_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = opmac_pkg::ACC_WIDTH_DEF,
  parameter int ROW        = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 stall,
  input  opmac_pkg::ctl_t                      in_ctl,
  input  logic [TILE-1:0][DATA_WIDTH-1:0]      in_a,
  input  logic [TILE-1:0][DATA_WIDTH-1:0]      in_b,
  output opmac_pkg::ctl_t                      out_ctl,
  output logic [TILE-1:0][DATA_WIDTH-1:0]      out_a,
  output logic [TILE-1:0][DATA_WIDTH-1:0]      out_b,
  output logic                                 fin,
  output logic [TILE-1:0][ACC_WIDTH-1:0]       fin_sums
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
  localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  opmac_pkg::ctl_t                      ctl;
  logic [TILE-1:0][DATA_WIDTH-1:0]      a_q;
  logic [TILE-1:0][DATA_WIDTH-1:0]      b_q;
  logic signed [PW-1:0]                 prod [TILE];
  logic signed [ACC_WIDTH-1:0]          acc  [TILE];
  logic [TILE-1:0][ACC_WIDTH-1:0]       acc_next;

  // Exact sum in a wide word, then clamp to the accumulator range.
  always_comb begin
    logic signed [SW-1:0] s;
    for (int c = 0; c < TILE; c++) begin
      s = SW'(acc[c]) + SW'(prod[c]);
      if (s > SMAX) begin
        s = SMAX;
      end else if (s < SMIN) begin
        s = SMIN;
      end
      acc_next[c] = s[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
      for (int c = 0; c < TILE; c++) begin
        acc[c] <= '0;
      end
    end else if (!stall) begin
      ctl <= in_ctl;
      if (ctl.valid) begin
        for (int c = 0; c < TILE; c++) begin
          acc[c] <= ctl.last ? '0 : $signed(acc_next[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      a_q <= in_a;
      b_q <= in_b;
      for (int c = 0; c < TILE; c++) begin
        prod[c] <= $signed(in_a[ROW]) * $signed(in_b[c]);
      end
    end
  end

  assign out_ctl  = ctl;
  assign out_a    = a_q;
  assign out_b    = b_q;
  assign fin      = ctl.valid && ctl.last;
  assign fin_sums = acc_next;

endmodule

`default_nettype wire
